FILE: rtl/core/ibe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibe_pkg
// shared types and constants of the i2c master byte engine
// ----------------------------------------------------------------------------
package ibe_pkg;

    localparam int BYTE_BITS = 8;
    localparam int TICK_W    = 16;
    localparam int RETRY_W   = 8;
    localparam int BITCNT_W  = 4;
    localparam int OPCODE_W  = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // command codes
    localparam logic [OPCODE_W-1:0] OP_START   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_STOP    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_RD_ACK  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_RD_NACK = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_RETRY   = 8'd1;

    localparam logic [TICK_W-1:0]  PHASE_TICKS_RST = 16'd10;
    localparam logic [RETRY_W-1:0] ACK_RETRY_RST   = 8'd50;

    typedef struct packed {
        logic                 sda_sample;
        logic [BYTE_BITS-1:0] tx_byte;
        logic [OPCODE_W-1:0]  opcode;
        logic                 cmd_valid;
    } item_t;

    typedef struct packed {
        logic                 ack_failed;
        logic                 cmd_done;
        logic [BYTE_BITS-1:0] rx_byte;
        logic                 busy_res;
        logic                 sda_level;
        logic                 scl_level;
    } result_t;

    typedef struct packed {
        logic [TICK_W-1:0]  plen;
        logic [RETRY_W-1:0] retry_limit;
    } timing_t;

endpackage

FILE: rtl/core/ibe_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibe_cfg_regs
// configuration registers: phase length and ack retry limit
// ----------------------------------------------------------------------------
module ibe_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [ibe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ibe_pkg::CFG_DAT_W-1:0] cfg_data,
    output ibe_pkg::timing_t              timing
);
    import ibe_pkg::*;

    logic [TICK_W-1:0]  phase_ticks_reg;
    logic [TICK_W-1:0]  phase_ticks_next;
    logic [RETRY_W-1:0] retry_limit_reg;
    logic [RETRY_W-1:0] retry_limit_next;

    always_comb
    begin
        phase_ticks_next = phase_ticks_reg;
        retry_limit_next = retry_limit_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PHASE_TICKS: phase_ticks_next = cfg_data[TICK_W-1:0];
                CFG_ACK_RETRY:   retry_limit_next = cfg_data[RETRY_W-1:0];
                default:
                begin
                    phase_ticks_next = phase_ticks_reg;
                    retry_limit_next = retry_limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            retry_limit_reg <= ACK_RETRY_RST;
        end
        else
        begin
            phase_ticks_reg <= phase_ticks_next;
            retry_limit_reg <= retry_limit_next;
        end
    end

    // zero length acts as one tick
    assign timing.plen        = (phase_ticks_reg == '0) ? TICK_W'(1) : phase_ticks_reg;
    assign timing.retry_limit = retry_limit_reg;

endmodule

FILE: rtl/core/ibe_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibe_engine
// bus phase sequencer: advances one tick per step and forms the result
// ----------------------------------------------------------------------------
module ibe_engine
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  ibe_pkg::item_t   item,
    input  ibe_pkg::timing_t timing,
    output ibe_pkg::result_t res
);
    import ibe_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_ST0  = 4'd1,
        PH_ST1  = 4'd2,
        PH_SP0  = 4'd3,
        PH_SP1  = 4'd4,
        PH_W0   = 4'd5,
        PH_W1   = 4'd6,
        PH_W2   = 4'd7,
        PH_A0   = 4'd8,
        PH_A1   = 4'd9,
        PH_POLL = 4'd10,
        PH_R0   = 4'd11,
        PH_R1   = 4'd12,
        PH_K0   = 4'd13,
        PH_K1   = 4'd14
    } phase_t;

    localparam logic [BITCNT_W-1:0] BITS_LAST = BITCNT_W'(BYTE_BITS);

    phase_t               phase_reg,  phase_next;
    logic [TICK_W-1:0]    tick_reg,   tick_next;
    logic [BITCNT_W-1:0]  bit_reg,    bit_next;
    logic [BYTE_BITS-1:0] shift_reg,  shift_next;
    logic [RETRY_W-1:0]   retry_reg,  retry_next;
    logic                 scl_reg,    scl_next;
    logic                 sda_reg,    sda_next;
    logic [OPCODE_W-1:0]  held_reg,   held_next;
    logic [BYTE_BITS-1:0] rx_reg,     rx_next;
    logic                 done;
    logic                 fail;
    logic [TICK_W-1:0]    tick_inc;
    logic [BITCNT_W-1:0]  bit_inc;
    logic [BYTE_BITS-1:0] shift_rd;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        retry_next = retry_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        held_next  = held_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        fail       = 1'b0;
        tick_inc   = tick_reg + TICK_W'(1);
        bit_inc    = bit_reg + BITCNT_W'(1);
        shift_rd   = {shift_reg[BYTE_BITS-2:0], item.sda_sample};

        if (step_en)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (item.cmd_valid && (item.opcode inside {[OP_START:OP_RD_NACK]}))
                begin
                    held_next  = item.opcode;
                    retry_next = '0;
                    bit_next   = '0;
                    tick_next  = '0;
                    case (item.opcode)
                        OP_START:
                        begin
                            phase_next = PH_ST0;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                        end
                        OP_STOP:
                        begin
                            phase_next = PH_SP0;
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                        end
                        OP_WRITE:
                        begin
                            shift_next = item.tx_byte;
                            phase_next = PH_W0;
                            scl_next   = 1'b0;
                            sda_next   = item.tx_byte[BYTE_BITS-1];
                        end
                        default:
                        begin
                            shift_next = '0;
                            phase_next = PH_R0;
                            scl_next   = 1'b0;
                            sda_next   = 1'b1;
                        end
                    endcase
                end
            end
            else
            begin
                tick_next = tick_inc;
                if (tick_inc >= timing.plen)
                begin
                    tick_next = '0;
                    case (phase_reg)
                        PH_ST0:
                        begin
                            phase_next = PH_ST1;
                            scl_next   = 1'b1;
                            sda_next   = 1'b0;
                        end
                        PH_ST1:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_SP0:
                        begin
                            phase_next = PH_SP1;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                        end
                        PH_SP1:
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            fail       = (held_reg == OP_WRITE);
                        end
                        PH_W0:
                        begin
                            phase_next = PH_W1;
                            scl_next   = 1'b1;
                        end
                        PH_W1:
                        begin
                            phase_next = PH_W2;
                            scl_next   = 1'b0;
                        end
                        PH_W2:
                        begin
                            bit_next   = bit_inc;
                            shift_next = {shift_reg[BYTE_BITS-2:0], 1'b0};
                            scl_next   = 1'b0;
                            if (bit_inc < BITS_LAST)
                            begin
                                phase_next = PH_W0;
                                sda_next   = shift_reg[BYTE_BITS-2];
                            end
                            else
                            begin
                                phase_next = PH_A0;
                                sda_next   = 1'b1;
                            end
                        end
                        PH_A0:
                        begin
                            phase_next = PH_A1;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                        end
                        PH_A1, PH_POLL:
                        begin
                            if (!item.sda_sample)
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else if (retry_reg >= timing.retry_limit)
                            begin
                                phase_next = PH_SP0;
                                scl_next   = 1'b0;
                                sda_next   = 1'b0;
                            end
                            else
                            begin
                                retry_next = retry_reg + RETRY_W'(1);
                                phase_next = PH_POLL;
                                scl_next   = 1'b1;
                                sda_next   = 1'b1;
                            end
                        end
                        PH_R0:
                        begin
                            phase_next = PH_R1;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                        end
                        PH_R1:
                        begin
                            shift_next = shift_rd;
                            bit_next   = bit_inc;
                            scl_next   = 1'b0;
                            if (bit_inc < BITS_LAST)
                            begin
                                phase_next = PH_R0;
                                sda_next   = 1'b1;
                            end
                            else
                            begin
                                rx_next    = shift_rd;
                                phase_next = PH_K0;
                                sda_next   = (held_reg == OP_RD_ACK) ? 1'b0 : 1'b1;
                            end
                        end
                        PH_K0:
                        begin
                            phase_next = PH_K1;
                            scl_next   = 1'b1;
                        end
                        PH_K1:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            retry_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            held_reg  <= '0;
            rx_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            retry_reg <= retry_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            held_reg  <= held_next;
            rx_reg    <= rx_next;
        end
    end

    // levels after this tick's update
    assign res.scl_level  = scl_next;
    assign res.sda_level  = sda_next;
    assign res.busy_res   = (phase_next != PH_IDLE);
    assign res.rx_byte    = rx_next;
    assign res.cmd_done   = done;
    assign res.ack_failed = fail;

`ifndef SYNTHESIS
    a_fail_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.ack_failed |-> res.cmd_done)
        else $error("ack_failed without cmd_done");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.cmd_done |-> !res.busy_res)
        else $error("cmd_done while busy");

    a_idle_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (tick_reg == '0))
        else $error("tick counter running while idle");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (phase_reg == PH_IDLE) && (!item.cmd_valid
            || (item.opcode > OP_RD_NACK)))
        |=> (phase_reg == PH_IDLE) && $stable(scl_reg) && $stable(sda_reg))
        else $error("engine left idle without a valid command");
`endif

endmodule

FILE: rtl/core/i2c_master_byte_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top
// i2c master byte engine with stream ports and a configuration write port
// ----------------------------------------------------------------------------
// Every input transfer is one tick of the bus timebase and yields exactly one
// result transfer with the SCL/SDA drive levels after that tick. One item is
// taken per clock cycle while the result side does not stall; a result passes
// the input register, then the result register, with the phase sequencer
// between them. Bus phase lengths are counted in input items, not in clock
// cycles. Configuration writes are taken in any cycle (cfg_ready is always
// high) and belong while the engine is idle.
module i2c_master_byte_engine_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // tx_byte, sda_sample
    input  logic [3:0]                    s_axis_tuser,  // cmd_valid, opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // scl_level, sda_level, busy_res, rx_byte, cmd_done, ack_failed
    output logic [15:0]                   m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ibe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ibe_pkg::CFG_DAT_W-1:0] cfg_data
);
    import ibe_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg,  in_item_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg,  out_res_next;
    logic    out_free;
    logic    advance;
    item_t   s_item;
    result_t step_res;
    timing_t timing;

    assign s_item.cmd_valid  = s_axis_tuser[0];
    assign s_item.opcode     = s_axis_tuser[3:1];
    assign s_item.tx_byte    = s_axis_tdata[7:0];
    assign s_item.sda_sample = s_axis_tdata[8];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    ibe_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    ibe_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .timing  (timing),
        .res     (step_res)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
            in_item_next  = s_item;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_res_next   = step_res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_res_reg};

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the i2c master byte engine
// ----------------------------------------------------------------------------
// Drives bus ticks into the stream input and checks every result against an
// in-bench model of the phase sequencer. A short directed table comes first,
// then random commands under several timing settings, with bursty input and
// a stalling result side.
module testbench;

    import ibe_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 4000;
    localparam int                   MAX_PRINTS     = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 8'hFF;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST0, PH_ST1, PH_SP0, PH_SP1, PH_W0, PH_W1, PH_W2,
        PH_A0, PH_A1, PH_POLL, PH_R0, PH_R1, PH_K0, PH_K1
    } bus_phase_e;

    typedef struct {
        item_t   tick;
        int      reps;
        bit      typed;
        result_t levels;
    } tick_row_t;

    localparam result_t IDLE_LEVELS = '{ack_failed: 1'b0, cmd_done: 1'b0, rx_byte: 8'h00,
                                        busy_res: 1'b0, sda_level: 1'b1, scl_level: 1'b1};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // tx_byte, sda_sample
    logic [3:0]           s_axis_tuser;   // cmd_valid, opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;   // scl, sda, busy, rx_byte, cmd_done, ack_failed
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // model of the engine
    bus_phase_e           eng_phase;
    logic [TICK_W-1:0]    eng_ticks;
    logic [BITCNT_W-1:0]  eng_bits;
    logic [7:0]           eng_shift;
    logic [RETRY_W-1:0]   eng_retries;
    logic                 eng_scl;
    logic                 eng_sda;
    logic [OPCODE_W-1:0]  eng_op;
    logic [7:0]           eng_rx;
    logic [TICK_W-1:0]    cfg_plen;
    logic [RETRY_W-1:0]   cfg_retry;

    result_t              bus_levels_q[$];
    tick_row_t            tick_table[$];
    int                   err_count;
    int                   burst_left;
    int                   results_seen;
    int                   hold_left;
    bit                   hold_done;
    int                   rcv_mode;
    int                   rcv_mode_left;
    int                   rcv_phase;
    int                   quiet_cycles;

    i2c_master_byte_engine_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void set_phase(input bus_phase_e p, input logic scl, input logic sda);
        eng_phase = p;
        eng_ticks = '0;
        eng_scl   = scl;
        eng_sda   = sda;
    endfunction

    function automatic result_t advance_bus_engine(input item_t it);
        logic [TICK_W-1:0] plen;
        logic              done;
        logic              fail;
        result_t           r;
        done = 1'b0;
        fail = 1'b0;
        plen = (cfg_plen == '0) ? TICK_W'(1) : cfg_plen;
        if (eng_phase == PH_IDLE)
        begin
            if (it.cmd_valid && it.opcode <= OP_RD_NACK)
            begin
                eng_op      = it.opcode;
                eng_retries = '0;
                eng_bits    = '0;
                case (it.opcode)
                    OP_START: set_phase(PH_ST0, 1'b1, 1'b1);
                    OP_STOP:  set_phase(PH_SP0, 1'b0, 1'b0);
                    OP_WRITE:
                    begin
                        eng_shift = it.tx_byte;
                        set_phase(PH_W0, 1'b0, it.tx_byte[7]);
                    end
                    default:
                    begin
                        eng_shift = '0;
                        set_phase(PH_R0, 1'b0, 1'b1);
                    end
                endcase
            end
        end
        else
        begin
            eng_ticks = eng_ticks + 1'b1;
            if (eng_ticks >= plen)
            begin
                eng_ticks = '0;
                case (eng_phase)
                    PH_ST0: set_phase(PH_ST1, 1'b1, 1'b0);
                    PH_ST1:
                    begin
                        eng_scl   = 1'b0;
                        eng_phase = PH_IDLE;
                        done      = 1'b1;
                    end
                    PH_SP0: set_phase(PH_SP1, 1'b1, 1'b1);
                    PH_SP1:
                    begin
                        eng_phase = PH_IDLE;
                        done      = 1'b1;
                        fail      = (eng_op == OP_WRITE);
                    end
                    PH_W0: set_phase(PH_W1, 1'b1, eng_sda);
                    PH_W1: set_phase(PH_W2, 1'b0, eng_sda);
                    PH_W2:
                    begin
                        eng_bits  = eng_bits + 1'b1;
                        eng_shift = {eng_shift[6:0], 1'b0};
                        if (eng_bits < BYTE_BITS)
                            set_phase(PH_W0, 1'b0, eng_shift[7]);
                        else
                            set_phase(PH_A0, 1'b0, 1'b1);
                    end
                    PH_A0: set_phase(PH_A1, 1'b1, 1'b1);
                    PH_A1, PH_POLL:
                    begin
                        if (!it.sda_sample)
                        begin
                            eng_scl   = 1'b0;
                            eng_phase = PH_IDLE;
                            done      = 1'b1;
                        end
                        else if (eng_retries >= cfg_retry)
                            set_phase(PH_SP0, 1'b0, 1'b0);
                        else
                        begin
                            eng_retries = eng_retries + 1'b1;
                            set_phase(PH_POLL, 1'b1, 1'b1);
                        end
                    end
                    PH_R0: set_phase(PH_R1, 1'b1, 1'b1);
                    PH_R1:
                    begin
                        eng_shift = {eng_shift[6:0], it.sda_sample};
                        eng_bits  = eng_bits + 1'b1;
                        if (eng_bits < BYTE_BITS)
                            set_phase(PH_R0, 1'b0, 1'b1);
                        else
                        begin
                            eng_rx = eng_shift;
                            set_phase(PH_K0, 1'b0, (eng_op == OP_RD_ACK) ? 1'b0 : 1'b1);
                        end
                    end
                    PH_K0: set_phase(PH_K1, 1'b1, eng_sda);
                    PH_K1:
                    begin
                        eng_scl   = 1'b0;
                        eng_phase = PH_IDLE;
                        done      = 1'b1;
                    end
                    default: set_phase(PH_IDLE, 1'b1, 1'b1);
                endcase
            end
        end
        r.scl_level  = eng_scl;
        r.sda_level  = eng_sda;
        r.busy_res   = (eng_phase != PH_IDLE);
        r.rx_byte    = eng_rx;
        r.cmd_done   = done;
        r.ack_failed = fail;
        return r;
    endfunction

    function automatic tick_row_t row(input logic cv, input logic [OPCODE_W-1:0] op,
                                      input logic [7:0] tx, input logic sda, input int reps,
                                      input bit typed);
        tick_row_t t;
        t.tick.cmd_valid  = cv;
        t.tick.opcode     = op;
        t.tick.tx_byte    = tx;
        t.tick.sda_sample = sda;
        t.reps            = reps;
        t.typed           = typed;
        t.levels          = IDLE_LEVELS;
        return t;
    endfunction

    function automatic item_t random_tick(input int sda_hi_pct);
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (eng_phase == PH_IDLE)
        begin
            it.cmd_valid = (pick < 85);
            it.opcode    = (pick < 6) ? OPCODE_W'($urandom_range(5, 7))
                                      : OPCODE_W'($urandom_range(0, 4));
        end
        else
        begin
            it.cmd_valid = (pick < 25);
            it.opcode    = OPCODE_W'($urandom_range(0, 7));
        end
        it.tx_byte    = 8'($urandom);
        it.sda_sample = ($urandom_range(0, 99) < sda_hi_pct);
        return it;
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    task automatic send_tick(input item_t it, input bit typed, input result_t levels);
        result_t r;
        int      gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(100, 300);
            end
            else
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
            end
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, it.sda_sample, it.tx_byte};
        s_axis_tuser  <= {it.opcode, it.cmd_valid};
        do @(posedge clk); while (!s_axis_tready);
        r = advance_bus_engine(it);
        bus_levels_q.push_back(typed ? levels : r);
    endtask

    task automatic settle(input int sda_hi_pct);
        while (eng_phase != PH_IDLE)
            send_tick(random_tick(sda_hi_pct), 1'b0, IDLE_LEVELS);
        s_axis_tvalid <= 1'b0;
        while (bus_levels_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_timing(input logic [CFG_DAT_W-1:0] plen,
                              input logic [RETRY_W-1:0] retry, input bit poke_unused);
        int n;
        n = poke_unused ? 3 : 2;
        for (int k = 0; k < n; k++)
        begin
            cfg_valid <= 1'b1;
            case (k)
                0:
                begin
                    cfg_index <= CFG_PHASE_TICKS;
                    cfg_data  <= plen;
                end
                1:
                begin
                    cfg_index <= CFG_ACK_RETRY;
                    cfg_data  <= {8'h00, retry};
                end
                default:
                begin
                    cfg_index <= CFG_UNUSED;
                    cfg_data  <= 16'hA5C3;
                end
            endcase
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cfg_plen  = plen;
        cfg_retry = retry;
    endtask

    // result side: checking, stall pattern, one long hold-off
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[12:0]);
            results_seen++;
            if (bus_levels_q.size() == 0)
                report("unexpected transfer", m_axis_tdata, '0);
            else
            begin
                want = bus_levels_q.pop_front();
                if (got.scl_level !== want.scl_level)
                    report("scl_level", 16'(got.scl_level), 16'(want.scl_level));
                if (got.sda_level !== want.sda_level)
                    report("sda_level", 16'(got.sda_level), 16'(want.sda_level));
                if (got.busy_res !== want.busy_res)
                    report("busy_res", 16'(got.busy_res), 16'(want.busy_res));
                if (got.rx_byte !== want.rx_byte)
                    report("rx_byte", 16'(got.rx_byte), 16'(want.rx_byte));
                if (got.cmd_done !== want.cmd_done)
                    report("cmd_done", 16'(got.cmd_done), 16'(want.cmd_done));
                if (got.ack_failed !== want.ack_failed)
                    report("ack_failed", 16'(got.ack_failed), 16'(want.ack_failed));
            end
        end
        if (!hold_done && results_seen >= 600)
        begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (rcv_mode_left == 0)
        begin
            rcv_mode      = $urandom_range(0, 2);
            rcv_mode_left = $urandom_range(50, 150);
        end
        rcv_mode_left--;
        rcv_phase = (rcv_phase + 1) % 3;
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            case (rcv_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 99) >= 40);
                default: m_axis_tready <= (rcv_phase == 0);
            endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [TICK_W-1:0]  plens[4];
        logic [RETRY_W-1:0] retries[4];
        int                 sda_pcts[4];
        int                 counts[4];

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        err_count     = 0;
        burst_left    = 0;
        results_seen  = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        rcv_mode      = 0;
        rcv_mode_left = 0;
        rcv_phase     = 0;
        quiet_cycles  = 0;

        eng_phase   = PH_IDLE;
        eng_ticks   = '0;
        eng_bits    = '0;
        eng_shift   = '0;
        eng_retries = '0;
        eng_scl     = 1'b1;
        eng_sda     = 1'b1;
        eng_op      = OP_START;
        eng_rx      = '0;
        cfg_plen    = PHASE_TICKS_RST;
        cfg_retry   = ACK_RETRY_RST;

        plens    = '{16'd0, 16'd1, 16'd3, 16'd2};
        retries  = '{8'd0, 8'd255, 8'd2, 8'd7};
        sda_pcts = '{50, 85, 60, 50};
        counts   = '{210, 210, 210, 210};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // after reset, unknown opcodes, then every command at reset timing
        tick_table.push_back(row(1'b0, OP_START,   8'h00, 1'b0, 1,   1'b1));
        tick_table.push_back(row(1'b1, 3'd5,       8'hFF, 1'b1, 1,   1'b1));
        tick_table.push_back(row(1'b1, 3'd6,       8'h0F, 1'b0, 1,   1'b1));
        tick_table.push_back(row(1'b1, 3'd7,       8'hF0, 1'b1, 1,   1'b1));
        tick_table.push_back(row(1'b1, OP_START,   8'h00, 1'b1, 1,   1'b0));
        tick_table.push_back(row(1'b0, OP_START,   8'h00, 1'b1, 25,  1'b0));
        tick_table.push_back(row(1'b1, OP_WRITE,   8'h00, 1'b0, 1,   1'b0));
        tick_table.push_back(row(1'b0, OP_START,   8'h00, 1'b0, 270, 1'b0));
        tick_table.push_back(row(1'b1, OP_START,   8'h00, 1'b1, 1,   1'b0));
        tick_table.push_back(row(1'b1, OP_STOP,    8'hFF, 1'b1, 1,   1'b0));
        tick_table.push_back(row(1'b0, OP_START,   8'h00, 1'b1, 25,  1'b0));
        tick_table.push_back(row(1'b1, OP_RD_ACK,  8'h00, 1'b1, 1,   1'b0));
        tick_table.push_back(row(1'b0, OP_START,   8'h00, 1'b1, 190, 1'b0));
        tick_table.push_back(row(1'b1, OP_RD_NACK, 8'hFF, 1'b0, 1,   1'b0));
        tick_table.push_back(row(1'b0, OP_START,   8'h00, 1'b0, 190, 1'b0));
        tick_table.push_back(row(1'b1, OP_STOP,    8'h00, 1'b0, 1,   1'b0));
        tick_table.push_back(row(1'b0, OP_START,   8'h00, 1'b0, 25,  1'b0));

        foreach (tick_table[i])
            for (int k = 0; k < tick_table[i].reps; k++)
                send_tick(tick_table[i].tick, tick_table[i].typed, tick_table[i].levels);
        settle(50);

        for (int p = 0; p < 4; p++)
        begin
            set_timing(plens[p], retries[p], p == 0);
            for (int n = 0; n < counts[p]; n++)
                send_tick(random_tick(sda_pcts[p]), 1'b0, IDLE_LEVELS);
            settle(sda_pcts[p]);
        end

        repeat (8) @(posedge clk);
        if (err_count == 0 && bus_levels_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
